### hdl/modular_power_and_inverse_top_defines.svh
// assertion macros for the modular power and inverse block
// used by the top level only, expects aclk and aresetn in scope
`ifndef MODULAR_POWER_AND_INVERSE_TOP_DEFINES_SVH
`define MODULAR_POWER_AND_INVERSE_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define MPI_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MPI_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mpi_pkg.sv
// shared types, constants and microcode rom for the modular power block
// no dependencies
package mpi_pkg;

    localparam int unsigned VAL_W        = 31;
    localparam int unsigned IN_EXP_W     = 63;
    localparam int unsigned EXP_BITS_DEF = 63;
    localparam int unsigned STEP_W       = 3;
    localparam logic [VAL_W-1:0] MOD_RESET = 31'd1000000007;

    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_INPUT,
        WAIT_MUL,
        WAIT_OUTPUT
    } wait_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_RED,
        MUL_SQR,
        MUL_BASE
    } mul_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_MOD_SMALL,
        COND_EBIT_CLR,
        COND_CNT_MORE
    } cond_t;

    typedef struct packed {
        wait_t wait_on;
        mul_t  mul;
        logic  load;
        logic  next_bit;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic mul_done;
        logic ebit;
        logic cnt_more;
        logic mod_small;
    } dp_stat_t;

    typedef struct packed {
        logic     in_fire;
        logic     out_free;
        dp_stat_t dp;
    } stat_t;

    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_CHECK  = 3'd1;
    localparam step_t STEP_REDUCE = 3'd2;
    localparam step_t STEP_SQUARE = 3'd3;
    localparam step_t STEP_TEST   = 3'd4;
    localparam step_t STEP_MULB   = 3'd5;
    localparam step_t STEP_NEXT   = 3'd6;
    localparam step_t STEP_DONE   = 3'd7;

    // square-and-multiply program, one control word per step
    function automatic ctrl_t ucode_rom(step_t step);
        ctrl_t w;
        w = '{WAIT_NONE, MUL_NONE, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_IDLE};
        unique case (step)
            STEP_IDLE: begin
                w.wait_on = WAIT_INPUT;
                w.load    = 1'b1;
            end
            STEP_CHECK: begin
                w.cond   = COND_MOD_SMALL;
                w.target = STEP_DONE;
            end
            STEP_REDUCE: begin
                w.wait_on = WAIT_MUL;
                w.mul     = MUL_RED;
            end
            STEP_SQUARE: begin
                w.wait_on = WAIT_MUL;
                w.mul     = MUL_SQR;
            end
            STEP_TEST: begin
                w.cond   = COND_EBIT_CLR;
                w.target = STEP_NEXT;
            end
            STEP_MULB: begin
                w.wait_on = WAIT_MUL;
                w.mul     = MUL_BASE;
            end
            STEP_NEXT: begin
                w.next_bit = 1'b1;
                w.cond     = COND_CNT_MORE;
                w.target   = STEP_SQUARE;
            end
            STEP_DONE: begin
                w.wait_on = WAIT_OUTPUT;
                w.emit    = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = STEP_IDLE;
            end
            default: ;
        endcase
        return w;
    endfunction

endpackage

### hdl/mpi_modmul.sv
// bit-serial modular multiplier, one bit of b per cycle, msb first
// depends on mpi_pkg; operand a must already be below the modulus
module mpi_modmul (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  mpi_pkg::val_t a,
    input  mpi_pkg::val_t b,
    input  mpi_pkg::val_t modulus,
    output logic          busy,
    output logic          done,
    output mpi_pkg::val_t result
);
    import mpi_pkg::*;

    localparam int unsigned CNT_W = $clog2(VAL_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    val_t             acc_reg;
    val_t             acc_next;
    val_t             a_reg;
    val_t             b_reg;

    logic [VAL_W:0] mod_ext;
    logic [VAL_W:0] dbl;
    logic [VAL_W:0] dbl_red;
    logic [VAL_W:0] sum;
    logic [VAL_W:0] sum_red;

    // acc = 2*acc + bit*a, each partial kept below the modulus
    always_comb begin
        mod_ext  = {1'b0, modulus};
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
        sum      = dbl_red + (b_reg[VAL_W-1] ? {1'b0, a_reg} : '0);
        sum_red  = (sum >= mod_ext) ? sum - mod_ext : sum;
        acc_next = sum_red[VAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            cnt_reg <= CNT_W'(VAL_W - 1);
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[VAL_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### hdl/mpi_datapath.sv
// datapath: accumulator, reduced base, exponent shifter, bit counter, multiplier
// depends on mpi_pkg and mpi_modmul; driven by the sequencer control word
module mpi_datapath #(
    parameter int unsigned EXP_BITS = mpi_pkg::EXP_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mpi_pkg::ctrl_t                  ctrl,
    input  logic                            in_fire,
    input  logic                            in_op,
    input  mpi_pkg::val_t                   in_base,
    input  logic [mpi_pkg::IN_EXP_W-1:0]    in_exp,
    input  mpi_pkg::val_t                   modulus,
    output mpi_pkg::dp_stat_t               dstat,
    output mpi_pkg::val_t                   result
);
    import mpi_pkg::*;

    localparam int unsigned CNT_W = $clog2(EXP_BITS);

    val_t                acc_reg;
    val_t                base_reg;
    logic [EXP_BITS-1:0] e_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [63:0]         e_wide;

    logic mul_start;
    logic mul_busy;
    logic mul_done;
    val_t mul_a;
    val_t mul_b;
    val_t mul_res;
    logic mod_small;

    assign mod_small = modulus < VAL_W'(2);

    // inverse uses modulus - 2 as exponent, only low EXP_BITS bits kept
    assign e_wide = in_op ? (64'(modulus) - 64'd2) : 64'(in_exp);

    always_comb begin
        unique case (ctrl.mul)
            MUL_RED: begin
                mul_a = VAL_W'(1);
                mul_b = base_reg;
            end
            MUL_SQR: begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            MUL_BASE: begin
                mul_a = base_reg;
                mul_b = acc_reg;
            end
            default: begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
        endcase
    end

    assign mul_start = (ctrl.mul != MUL_NONE) && !mul_busy && !mul_done;

    mpi_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .modulus (modulus),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.load && in_fire) begin
            base_reg <= in_base;
            e_reg    <= e_wide[EXP_BITS-1:0];
            acc_reg  <= VAL_W'(1);
            cnt_reg  <= CNT_W'(EXP_BITS - 1);
        end else begin
            if (mul_done) begin
                if (ctrl.mul == MUL_RED) begin
                    base_reg <= mul_res;
                end else begin
                    acc_reg <= mul_res;
                end
            end
            if (ctrl.next_bit) begin
                e_reg   <= {e_reg[EXP_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    assign dstat.mul_done  = mul_done;
    assign dstat.ebit      = e_reg[EXP_BITS-1];
    assign dstat.cnt_more  = cnt_reg != '0;
    assign dstat.mod_small = mod_small;
    assign result          = mod_small ? '0 : acc_reg;

endmodule

### hdl/mpi_sequencer.sv
// microcode sequencer: step counter, rom fetch, wait and jump logic
// depends on mpi_pkg (control word layout and program)
module mpi_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  mpi_pkg::stat_t stat,
    output mpi_pkg::ctrl_t ctrl
);
    import mpi_pkg::*;

    step_t step_reg;
    step_t step_next;
    ctrl_t word;
    logic  go;
    logic  jump;

    assign word = ucode_rom(step_reg);
    assign ctrl = word;

    always_comb begin
        unique case (word.wait_on)
            WAIT_NONE:   go = 1'b1;
            WAIT_INPUT:  go = stat.in_fire;
            WAIT_MUL:    go = stat.dp.mul_done;
            WAIT_OUTPUT: go = stat.out_free;
            default:     go = 1'b0;
        endcase
    end

    always_comb begin
        unique case (word.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_MOD_SMALL: jump = stat.dp.mod_small;
            COND_EBIT_CLR:  jump = !stat.dp.ebit;
            COND_CNT_MORE:  jump = stat.dp.cnt_more;
            default:        jump = 1'b0;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (go) begin
            step_next = jump ? word.target : step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

### hdl/modular_power_and_inverse_top.sv
// modular power and fermat inverse by square-and-multiply, one item at a time
// each exponent bit costs a squaring and each set exponent bit a further product, after one
//   reduction of the base, every modular product running in the one bit-serial multiplier
// a new item is taken only once the last result is registered for output; a modulus below two
//   skips the loop; a stalled result holds the next item back
// reset: synchronous active-low aresetn; modulus returns to 1000000007, no result held
`include "modular_power_and_inverse_top_defines.svh"

module modular_power_and_inverse_top #(
    parameter int unsigned EXP_BITS = mpi_pkg::EXP_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [mpi_pkg::VAL_W-1:0] cfg_wdata,   // modulus
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [95:0]               s_tdata,     // base [30:0], exponent [93:31], zero pad
    input  logic [0:0]                s_tuser,     // op [0]: 0 power, 1 inverse
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata      // result [30:0], zero pad
);
    import mpi_pkg::*;

    val_t     modulus_reg;
    logic     m_tvalid_reg;
    val_t     m_data_reg;
    ctrl_t    ctrl;
    stat_t    stat;
    dp_stat_t dstat;
    val_t     dp_result;
    logic     in_fire;
    logic     out_free;
    logic     emit_fire;
    logic     small_emit;

    assign s_tready  = ctrl.wait_on == WAIT_INPUT;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = ctrl.emit && out_free;
    assign small_emit = emit_fire && (modulus_reg < VAL_W'(2));

    assign stat.in_fire  = in_fire;
    assign stat.out_free = out_free;
    assign stat.dp       = dstat;

    mpi_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    mpi_datapath #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .in_fire (in_fire),
        .in_op   (s_tuser[0]),
        .in_base (s_tdata[VAL_W-1:0]),
        .in_exp  (s_tdata[VAL_W+IN_EXP_W-1:VAL_W]),
        .modulus (modulus_reg),
        .dstat   (dstat),
        .result  (dp_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= MOD_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                modulus_reg <= cfg_wdata;
            end
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_data_reg <= dp_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    `MPI_AST_NEXT(a_leave_idle, in_fire, !s_tready, "sequencer stayed idle after a transfer")
    `MPI_AST_NEXT(a_small_mod_zero, small_emit, m_data_reg == '0, "small modulus gave nonzero")
    `MPI_AST_NEXT(a_emit_back_idle, emit_fire, m_tvalid_reg && s_tready, "no result or not idle")

endmodule
